// ----- rtl/ndt_pkg.sv -----
package ndt_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_STOP  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    K_CLOSED  = 3'd0,
    K_RETRIG  = 3'd1,
    K_STOPINC = 3'd2,
    K_BADCH   = 3'd3,
    K_STATUS  = 3'd4,
    K_REJECT  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RES,
    S_STAT,
    S_SCAN,
    S_SOUT
  } state_e;

  typedef enum logic [1:0] {
    CAM_NONE,
    CAM_SET,
    CAM_CLR,
    CAM_CLEAR_ALL
  } cam_op_e;

  typedef struct packed {
    logic [3:0] ch;
    logic [6:0] note;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [6:0]  vel;
    logic [31:0] start;
  } entry_t;

  typedef struct packed {
    cam_op_e op;
    key_t    key;
  } cam_cmd_t;

  localparam logic [15:0] MinDurReset = 16'd48;
  localparam logic [4:0]  ChLo        = 5'd1;
  localparam logic [4:0]  ChHi        = 5'd16;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/ndt_mem.sv -----
module ndt_mem #(
  parameter int N  = 32,
  parameter int IW = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  ndt_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output ndt_pkg::entry_t rdata_o
);
  import ndt_pkg::*;

  entry_t mem_q [N];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ndt_cam.sv -----
module ndt_cam #(
  parameter int N  = 32,
  parameter int IW = 5,
  parameter int CW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ndt_pkg::cam_cmd_t cmd_i,
  input  logic [IW-1:0]     cmd_idx_i,
  input  ndt_pkg::key_t     look_key_i,
  input  logic              look_en_i,
  output logic              hit_o,
  output logic [IW-1:0]     hit_idx_o,
  output logic              free_o,
  output logic [IW-1:0]     free_idx_o,
  output logic              any_o,
  output logic [IW-1:0]     first_idx_o,
  output logic [CW-1:0]     count_o
);
  import ndt_pkg::*;

  logic [N-1:0] vld_q, vld_d;
  key_t         key_q [N];

  always_comb begin
    vld_d = vld_q;
    case (cmd_i.op)
      CAM_SET:       vld_d[cmd_idx_i] = 1'b1;
      CAM_CLR:       vld_d[cmd_idx_i] = 1'b0;
      CAM_CLEAR_ALL: vld_d = '0;
      default:       vld_d = vld_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CAM_SET) begin
      key_q[cmd_idx_i] <= cmd_i.key;
    end
  end

  always_comb begin
    hit_o       = 1'b0;
    hit_idx_o   = '0;
    free_o      = 1'b0;
    free_idx_o  = '0;
    any_o       = 1'b0;
    first_idx_o = '0;
    count_o     = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vld_q[i] && look_en_i && key_q[i] == look_key_i) begin
        hit_o     = 1'b1;
        hit_idx_o = IW'(i);
      end
      if (!vld_q[i]) begin
        free_o     = 1'b1;
        free_idx_o = IW'(i);
      end else begin
        any_o       = 1'b1;
        first_idx_o = IW'(i);
      end
    end
    for (int i = 0; i < N; i++) begin
      count_o = count_o + CW'(vld_q[i]);
    end
  end

endmodule

// ----- rtl/midi_note_duration_tracker.sv -----
// an accepted transaction passes key lookup, entry ram read and result load; a retrigger then also loads a status
// a new transaction is taken only in idle, after the previous one has loaded its results
// stop while recording: each open note is read from the entry ram, then output; a final status follows
// reset: asynchronous, clears recording, counters and all entry valid bits
// min_duration_ticks resets to 48
module midi_note_duration_tracker #(
  parameter int MAX_ACTIVE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  channel_i,
  input  logic [6:0]  note_number_i,
  input  logic [6:0]  velocity_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [4:0]  out_channel_o,
  output logic [6:0]  out_note_o,
  output logic [6:0]  out_velocity_o,
  output logic [31:0] start_time_o,
  output logic [31:0] duration_o,
  output logic        last_o,
  output logic [31:0] notes_recorded_o,
  output logic [31:0] incomplete_notes_o,
  output logic [31:0] channel_errors_o,
  output logic        table_full_o,
  output logic        recording_o
);
  import ndt_pkg::*;

  localparam int IW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int CW = $clog2(MAX_ACTIVE + 1);

  state_e      state_q, state_d;
  opcode_e     op_q;
  logic [4:0]  ch_q;
  logic [6:0]  nn_q, vel_q;
  logic [31:0] ts_q;
  logic [15:0] min_q;
  logic        rec_q, rec_d;
  logic [31:0] started_q, started_d, inc_q, inc_d, bad_q, bad_d;
  logic        hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;
  logic [CW-1:0] cnt_q;

  logic          cam_hit, cam_free, cam_any;
  logic [IW-1:0] cam_hit_idx, cam_free_idx, cam_first_idx, cam_idx;
  logic [CW-1:0] cam_count;
  cam_cmd_t      cam_cmd;
  key_t          look_key;
  logic          vch;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, rd;

  logic        out_valid_q, out_free, out_load;
  kind_e       o_kind;
  logic [4:0]  o_ch;
  logic [6:0]  o_note, o_vel;
  logic [31:0] o_start, o_dur, dur;
  logic        o_last, o_full, short_dur;
  logic [32:0] inc_sum;

  logic [2:0]  kind_q;
  logic [4:0]  och_q;
  logic [6:0]  onote_q, ovel_q;
  logic [31:0] ostart_q, odur_q, ostarted_q, oinc_q, obad_q;
  logic        olast_q, ofull_q, orec_q;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, min_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinDurReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      min_q <= pwdata[15:0];
    end
  end

  assign vch       = (ch_q >= ChLo) && (ch_q <= ChHi);
  assign look_key  = '{ch: 4'(ch_q - 5'd1), note: nn_q};
  assign mem_wdata = '{key: look_key, vel: vel_q, start: ts_q};

  ndt_cam #(.N(MAX_ACTIVE), .IW(IW), .CW(CW)) u_cam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cam_cmd),
    .cmd_idx_i   (cam_idx),
    .look_key_i  (look_key),
    .look_en_i   (vch),
    .hit_o       (cam_hit),
    .hit_idx_o   (cam_hit_idx),
    .free_o      (cam_free),
    .free_idx_o  (cam_free_idx),
    .any_o       (cam_any),
    .first_idx_o (cam_first_idx),
    .count_o     (cam_count)
  );

  ndt_mem #(.N(MAX_ACTIVE), .IW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign dur        = ts_q - rd.start;
  assign short_dur  = dur < {16'd0, min_q};
  assign inc_sum    = {1'b0, inc_q} + 33'(cnt_q);

  always_comb begin
    state_d   = state_q;
    rec_d     = rec_q;
    started_d = started_q;
    inc_d     = inc_q;
    bad_d     = bad_q;
    cam_cmd   = '{op: CAM_NONE, key: look_key};
    cam_idx   = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    o_kind    = K_STATUS;
    o_ch      = ch_q;
    o_note    = nn_q;
    o_vel     = vel_q;
    o_start   = ts_q;
    o_dur     = '0;
    o_last    = 1'b1;
    o_full    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        mem_re    = 1'b1;
        mem_raddr = cam_hit_idx;
        state_d   = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (op_q)
            OP_START: begin
              if (rec_q) begin
                o_kind = K_REJECT;
              end else begin
                cam_cmd.op = CAM_CLEAR_ALL;
                rec_d      = 1'b1;
              end
            end
            OP_STOP: begin
              if (rec_q) begin
                out_load = 1'b0;
                rec_d    = 1'b0;
                inc_d    = inc_sum[32] ? 32'hFFFF_FFFF : inc_sum[31:0];
                state_d  = S_SCAN;
              end
            end
            default: begin
              if (rec_q && op_q == OP_ON && vel_q != 7'd0) begin
                if (!vch) begin
                  bad_d  = sat_inc(bad_q);
                  o_kind = K_BADCH;
                end else if (hit_q) begin
                  o_kind    = K_RETRIG;
                  o_vel     = rd.vel;
                  o_start   = rd.start;
                  o_dur     = short_dur ? 32'd0 : dur;
                  o_last    = 1'b0;
                  inc_d     = short_dur ? sat_inc(inc_q) : inc_q;
                  started_d = sat_inc(started_q);
                  mem_we    = 1'b1;
                  mem_waddr = hit_idx_q;
                  state_d   = S_STAT;
                end else if (free_q) begin
                  started_d  = sat_inc(started_q);
                  mem_we     = 1'b1;
                  mem_waddr  = free_idx_q;
                  cam_cmd.op = CAM_SET;
                  cam_idx    = free_idx_q;
                end else begin
                  o_full = 1'b1;
                end
              end else if (rec_q && hit_q) begin
                o_kind     = K_CLOSED;
                o_vel      = rd.vel;
                o_start    = rd.start;
                o_dur      = dur;
                cam_cmd.op = CAM_CLR;
                cam_idx    = hit_idx_q;
              end
            end
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cam_any) begin
          mem_re     = 1'b1;
          mem_raddr  = cam_first_idx;
          cam_cmd.op = CAM_CLR;
          cam_idx    = cam_first_idx;
          state_d    = S_SOUT;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind   = K_STOPINC;
          o_ch     = {1'b0, rd.key.ch} + 5'd1;
          o_note   = rd.key.note;
          o_vel    = rd.vel;
          o_start  = rd.start;
          o_last   = 1'b0;
          state_d  = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rec_q       <= 1'b0;
      started_q   <= '0;
      inc_q       <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rec_q     <= rec_d;
      started_q <= started_d;
      inc_q     <= inc_d;
      bad_q     <= bad_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= opcode_e'(opcode_i);
      ch_q  <= channel_i;
      nn_q  <= note_number_i;
      vel_q <= velocity_i;
      ts_q  <= timestamp_i;
    end
    if (state_q == S_LOOK) begin
      hit_q      <= cam_hit;
      hit_idx_q  <= cam_hit_idx;
      free_q     <= cam_free;
      free_idx_q <= cam_free_idx;
      cnt_q      <= cam_count;
    end
    if (out_load) begin
      kind_q     <= o_kind;
      och_q      <= o_ch;
      onote_q    <= o_note;
      ovel_q     <= o_vel;
      ostart_q   <= o_start;
      odur_q     <= o_dur;
      olast_q    <= o_last;
      ofull_q    <= o_full;
      ostarted_q <= started_d;
      oinc_q     <= inc_d;
      obad_q     <= bad_d;
      orec_q     <= rec_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign out_channel_o      = och_q;
  assign out_note_o         = onote_q;
  assign out_velocity_o     = ovel_q;
  assign start_time_o       = ostart_q;
  assign duration_o         = odur_q;
  assign last_o             = olast_q;
  assign notes_recorded_o   = ostarted_q;
  assign incomplete_notes_o = oinc_q;
  assign channel_errors_o   = obad_q;
  assign table_full_o       = ofull_q;
  assign recording_o        = orec_q;

  a_scan_not_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SOUT) |-> !rec_q)
    else $error("scan while recording");

  a_stat_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STAT) |-> out_valid_q)
    else $error("status without pending retrigger");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LOOK))
    else $error("accepted transaction not looked up");

  a_rec_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rec_q) |-> (op_q == OP_STOP))
    else $error("recording ended without stop");

endmodule
